### hw/rtl/fbab_pkg.sv
// ----------------------------------------------------------------------------
// fbab_pkg
// Shared types and constants of the alpha-blending frame store.
// ----------------------------------------------------------------------------
package fbab_pkg;

  // Frame geometry
  localparam int Width  = 1024;
  localparam int Height = 768;
  localparam int Depth  = Width * Height;
  localparam int AddrW  = $clog2(Depth);

  // Command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Fully opaque and fully transparent alpha
  localparam logic [7:0] AlphaFull = 8'hFF;
  localparam logic [7:0] AlphaNone = 8'h00;

  // Input op codes
  localparam logic OpDraw = 1'b0;
  localparam logic OpRead = 1'b1;

  // Input beat
  typedef struct packed {
    logic        op;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
  } fbab_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       in_frame;
  } fbab_out_t;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BLEND = 2'd1,
    CMD_READ  = 2'd2,
    CMD_MISS  = 2'd3
  } fbab_kind_e;

  // Queue entry
  typedef struct packed {
    fbab_kind_e       kind;
    logic [AddrW-1:0] addr;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } fbab_cmd_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } fbab_qstat_t;

endpackage

### hw/rtl/fbab_front.sv
// ----------------------------------------------------------------------------
// fbab_front
// Accepts input beats, checks bounds and alpha, and turns each beat into a
// queue command. Skipped draws are dropped here.
// ----------------------------------------------------------------------------
module fbab_front import fbab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fbab_in_t    in_data_i,
  output logic        full_o,
  input  fbab_qstat_t q_stat_i,
  output logic        q_push_o,
  output fbab_cmd_t   q_cmd_o
);

  logic accept;
  logic in_bounds;
  logic keep;

  assign full_o = q_stat_i.full;
  assign accept = push_i && !q_stat_i.full;

  // Bounds check, linear address and classification
  always_comb begin
    in_bounds = (int'(in_data_i.x_pos) < Width) && (int'(in_data_i.y_pos) < Height);
    q_cmd_o.addr  = AddrW'(int'(in_data_i.y_pos) * Width + int'(in_data_i.x_pos));
    q_cmd_o.red   = in_data_i.src_red;
    q_cmd_o.green = in_data_i.src_green;
    q_cmd_o.blue  = in_data_i.src_blue;
    q_cmd_o.alpha = in_data_i.src_alpha;
    keep          = 1'b1;
    if (in_data_i.op == OpRead) begin
      q_cmd_o.kind = in_bounds ? CMD_READ : CMD_MISS;
    end else if (in_data_i.src_alpha == AlphaFull) begin
      q_cmd_o.kind = CMD_WRITE;
      keep         = in_bounds;
    end else begin
      q_cmd_o.kind = CMD_BLEND;
      keep         = in_bounds && (in_data_i.src_alpha != AlphaNone);
    end
  end

  assign q_push_o = accept && keep;

  // A push never meets a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_stat_i.full)
    else $error("front pushed into a full queue");

  // Skipped draws never reach the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.op == OpDraw && in_data_i.src_alpha == AlphaNone) |-> !q_push_o)
    else $error("zero-alpha draw was queued");

  // Every accepted read is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.op == OpRead) |-> q_push_o)
    else $error("read beat was dropped");

endmodule

### hw/rtl/fbab_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fbab_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fbab_cmd_fifo import fbab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fbab_cmd_t   cmd_i,
  input  logic        pop_i,
  output fbab_cmd_t   cmd_o,
  output fbab_qstat_t stat_o
);

  fbab_cmd_t        slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = slot_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hw/rtl/fbab_back.sv
// ----------------------------------------------------------------------------
// fbab_back
// Executes queued commands against the frame memory: overwrite, blend
// read-modify-write and read, with a one-beat result register.
// ----------------------------------------------------------------------------
module fbab_back import fbab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fbab_qstat_t q_stat_i,
  input  fbab_cmd_t   q_cmd_i,
  output logic        q_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output fbab_out_t   out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_MIX   = 3'b100
  } st_e;

  st_e              st_q, st_d;
  fbab_cmd_t        cur_q, cur_d;
  logic [23:0]      mem_q [Depth];
  logic [23:0]      rdata_q;
  logic             rd_en;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [23:0]      wdata;
  logic [15:0]      mix_r_q, mix_g_q, mix_b_q;
  logic [15:0]      mix_r_d, mix_g_d, mix_b_d;
  logic [7:0]       inv_a;
  logic             out_valid_q;
  fbab_out_t        out_q, out_d;
  logic             out_free;
  logic             load_out;

  assign out_free = !out_valid_q || pop_i;
  assign empty_o  = !out_valid_q;
  assign out_data_o = out_q;

  // Blend products from the fetched pixel
  always_comb begin
    inv_a   = AlphaFull - cur_q.alpha;
    mix_r_d = 16'(cur_q.red)   * 16'(cur_q.alpha) + 16'(rdata_q[23:16]) * 16'(inv_a);
    mix_g_d = 16'(cur_q.green) * 16'(cur_q.alpha) + 16'(rdata_q[15:8])  * 16'(inv_a);
    mix_b_d = 16'(cur_q.blue)  * 16'(cur_q.alpha) + 16'(rdata_q[7:0])   * 16'(inv_a);
  end

  // Sequencer
  always_comb begin
    st_d     = st_q;
    cur_d    = cur_q;
    q_pop_o  = 1'b0;
    rd_en    = 1'b0;
    we       = 1'b0;
    waddr    = q_cmd_i.addr;
    wdata    = {q_cmd_i.red, q_cmd_i.green, q_cmd_i.blue};
    load_out = 1'b0;
    out_d    = '0;
    case (st_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          case (q_cmd_i.kind)
            CMD_WRITE: begin
              we      = 1'b1;
              q_pop_o = 1'b1;
            end
            CMD_MISS: begin
              if (out_free) begin
                load_out = 1'b1;
                q_pop_o  = 1'b1;
              end
            end
            CMD_READ, CMD_BLEND: begin
              rd_en   = 1'b1;
              cur_d   = q_cmd_i;
              q_pop_o = 1'b1;
              st_d    = ST_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (cur_q.kind == CMD_READ) begin
          if (out_free) begin
            load_out          = 1'b1;
            out_d.pixel_red   = rdata_q[23:16];
            out_d.pixel_green = rdata_q[15:8];
            out_d.pixel_blue  = rdata_q[7:0];
            out_d.in_frame    = 1'b1;
            st_d              = ST_IDLE;
          end
        end else begin
          st_d = ST_MIX;
        end
      end
      ST_MIX: begin
        we    = 1'b1;
        waddr = cur_q.addr;
        wdata = {mix_r_q[15:8], mix_g_q[15:8], mix_b_q[15:8]};
        st_d  = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (st_q == ST_FETCH) begin
      mix_r_q <= mix_r_d;
      mix_g_q <= mix_g_d;
      mix_b_q <= mix_b_d;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Frame memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[q_cmd_i.addr];
    end
  end

  // Result register is only loaded when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result register overwritten");

  // Write-back always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MIX) |=> (st_q == ST_IDLE))
    else $error("blend write-back did not finish");

  // Queue is only drained while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (st_q == ST_IDLE && !q_stat_i.empty))
    else $error("command popped outside idle");

  // No memory write while a fetched pixel is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FETCH) |-> !we)
    else $error("write during fetch");

endmodule

### hw/rtl/framebuffer_alpha_blend_store_top.sv
// ----------------------------------------------------------------------------
// framebuffer_alpha_blend_store_top
// RGB frame store with alpha-blended pixel draws and pixel reads.
// ----------------------------------------------------------------------------
// Draw and read beats enter through a queue-style port (push/full) and are
// checked and classified at once; out-of-frame and zero-alpha draws are
// dropped there and cost nothing further. The rest pass through a four-entry
// command queue to an executor that owns the single-port frame memory with a
// registered read: an opaque draw is written at once, an out-of-frame read
// loads an out-of-frame result, an in-frame read passes a fetch state and a
// blend steps through read, multiply and write back, one command at a time, so
// the rate is set by that memory sequence. Input is taken every cycle while
// the queue has room. Read results wait in a one-beat register (empty/pop).
// The frame memory has no reset; a pixel holds no defined value until drawn.
// ----------------------------------------------------------------------------
module framebuffer_alpha_blend_store_top import fbab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  fbab_in_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output fbab_out_t out_data_o
);

  fbab_qstat_t q_stat;
  logic        q_push;
  logic        q_pop;
  fbab_cmd_t   q_cmd_in;
  fbab_cmd_t   q_cmd_out;

  // Front: accept and classify
  fbab_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  // Command queue
  fbab_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd_out),
    .stat_o (q_stat)
  );

  // Back: memory access and results
  fbab_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule
